@@ rtl/core/triangle_face_normal_defines.svh @@
// Assertion macros for the triangle face normal block.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("triangle_face_normal: same-cycle check failed");
`define TFN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("triangle_face_normal: next-cycle check failed");
`else
`define TFN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TFN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/tfn_pkg.sv @@
`default_nettype none
package tfn_pkg;
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned OUT_FRAC        = 14;
  localparam int unsigned OUT_WIDTH       = 16;
endpackage
`default_nettype wire

@@ rtl/core/tfn_in_if.sv @@
`default_nettype none
interface tfn_in_if import tfn_pkg::*; #(
  parameter int unsigned W = COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ax, ay, az;
  logic signed [W-1:0] bx, by, bz;
  logic signed [W-1:0] cx, cy, cz;

  modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tfn_out_if.sv @@
`default_nettype none
interface tfn_out_if import tfn_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] normal_x, normal_y, normal_z;

  modport source(output valid, normal_x, normal_y, normal_z, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

@@ rtl/core/triangle_face_normal.sv @@
// Unit face normal of a triangle.
// Input channel in_i: one request carries vertices A, B and C as signed
// Q2.14 coordinates (COORD_WIDTH bits each). Output channel out_o: one
// result per request, the unit normal of (B-A) x (C-A) in signed Q2.14,
// rounded to nearest with ties away from zero, or zero for a degenerate
// triangle. Both channels use a valid/ready handshake.
// From an accepted request to its result, the stages are: edge
// vectors, cross products, magnitudes, split squaring, squared length,
// then one pipeline stage per result bit of the exact rounding search,
// and the output register. A new request is taken every cycle unless stalled.
// All stages advance together. When the receiver holds ready low while a
// result waits, the whole pipeline freezes and in_i.ready drops in the
// same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty right after reset.
`default_nettype none
`include "triangle_face_normal_defines.svh"
module triangle_face_normal import tfn_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfn_in_if.sink    in_i,
  tfn_out_if.source out_o
);
  localparam int unsigned EW    = COORD_WIDTH + 1;
  localparam int unsigned PW    = 2 * EW;
  localparam int unsigned CW    = PW + 1;
  localparam int unsigned MW    = PW;
  localparam int unsigned HL    = MW / 2;
  localparam int unsigned HH    = MW - HL;
  localparam int unsigned M2W   = 2 * MW;
  localparam int unsigned LW    = M2W + 2;
  localparam int unsigned STEPS = OUT_FRAC + 1;
  localparam int unsigned AW    = LW + 2 * (OUT_FRAC + 2) + 2;
  localparam logic signed [OUT_WIDTH-1:0] ONE_Q = OUT_WIDTH'(1 << OUT_FRAC);

  logic en;
  logic out_vld_q;
  logic out_zero_q;
  logic signed [OUT_WIDTH-1:0] nrm_q [3];

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Edge vectors.
  logic                 v1_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EW'(in_i.bx) - EW'(in_i.ax);
      e1_q[1] <= EW'(in_i.by) - EW'(in_i.ay);
      e1_q[2] <= EW'(in_i.bz) - EW'(in_i.az);
      e2_q[0] <= EW'(in_i.cx) - EW'(in_i.ax);
      e2_q[1] <= EW'(in_i.cy) - EW'(in_i.ay);
      e2_q[2] <= EW'(in_i.cz) - EW'(in_i.az);
    end
  end

  // Cross product terms, two per component.
  logic                 v2_q;
  logic signed [PW-1:0] pr_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0] <= PW'(e1_q[1]) * PW'(e2_q[2]);
      pr_q[1] <= PW'(e1_q[2]) * PW'(e2_q[1]);
      pr_q[2] <= PW'(e1_q[2]) * PW'(e2_q[0]);
      pr_q[3] <= PW'(e1_q[0]) * PW'(e2_q[2]);
      pr_q[4] <= PW'(e1_q[0]) * PW'(e2_q[1]);
      pr_q[5] <= PW'(e1_q[1]) * PW'(e2_q[0]);
    end
  end

  // Sign and magnitude of each component.
  logic                 v3_q;
  logic [MW-1:0]        m_q [3];
  logic [2:0]           n3_q;
  logic signed [CW-1:0] dif [3];
  logic [CW-1:0]        dabs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k]  = CW'(pr_q[2*k]) - CW'(pr_q[2*k+1]);
      dabs[k] = dif[k][CW-1] ? CW'(-dif[k]) : CW'(dif[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k]  <= dabs[k][MW-1:0];
        n3_q[k] <= dif[k][CW-1];
      end
    end
  end

  // Squares from half-width partial products.
  logic            v4_q;
  logic [2*HH-1:0] hh_q [3];
  logic [MW-1:0]   hl_q [3];
  logic [2*HL-1:0] ll_q [3];
  logic [2:0]      n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= (2*HH)'(m_q[k][MW-1:HL]) * (2*HH)'(m_q[k][MW-1:HL]);
        hl_q[k] <= MW'(m_q[k][MW-1:HL]) * MW'(m_q[k][HL-1:0]);
        ll_q[k] <= (2*HL)'(m_q[k][HL-1:0]) * (2*HL)'(m_q[k][HL-1:0]);
      end
      n4_q <= n3_q;
    end
  end

  logic           v5_q;
  logic [M2W-1:0] m2_q [3];
  logic [2:0]     n5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m2_q[k] <= (M2W'(hh_q[k]) << (2 * HL)) + (M2W'(hl_q[k]) << (HL + 1))
                   + M2W'(ll_q[k]);
      end
      n5_q <= n4_q;
    end
  end

  // Rounding search. Result bit b is kept when (2q-1)^2 * L <= m^2 * 2^30
  // for the candidate q. S holds (2q-1)^2 * L and P holds (2q-1) * L for
  // the bits accepted so far, so each stage needs only shifts and adds.
  logic [LW-1:0] l_d;
  assign l_d = LW'(m2_q[0]) + LW'(m2_q[1]) + LW'(m2_q[2]);

  logic [STEPS:0]        sv_q;
  logic [AW-1:0]         s_q [STEPS+1][3];
  logic signed [AW:0]    p_q [STEPS+1][3];
  logic [AW-1:0]         t_q [STEPS+1][3];
  logic [STEPS-1:0]      q_q [STEPS+1][3];
  logic [LW-1:0]         l_q [STEPS+1];
  logic [2:0]            n_q [STEPS+1];
  logic [STEPS:0]        z_q;
  logic signed [AW:0]    cand [STEPS][3];
  logic [2:0]            take [STEPS];

  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      for (int k = 0; k < 3; k++) begin
        cand[j][k] = $signed({1'b0, s_q[j][k]})
                     + (p_q[j][k] <<< (OUT_FRAC - j + 2))
                     + $signed({1'b0, AW'(l_q[j]) << (2 * (OUT_FRAC - j) + 2)});
        take[j][k] = cand[j][k] <= $signed({1'b0, t_q[j][k]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[STEPS-1:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s_q[0][k] <= AW'(l_d);
        p_q[0][k] <= -$signed({1'b0, AW'(l_d)});
        t_q[0][k] <= AW'(m2_q[k]) << (2 * OUT_FRAC + 2);
        q_q[0][k] <= '0;
      end
      l_q[0] <= l_d;
      n_q[0] <= n5_q;
      z_q[0] <= (l_d == '0);
      for (int j = 0; j < STEPS; j++) begin
        for (int k = 0; k < 3; k++) begin
          s_q[j+1][k] <= take[j][k] ? cand[j][k][AW-1:0] : s_q[j][k];
          p_q[j+1][k] <= take[j][k]
                         ? p_q[j][k] + $signed({1'b0, AW'(l_q[j]) << (OUT_FRAC - j + 1)})
                         : p_q[j][k];
          t_q[j+1][k] <= t_q[j][k];
          q_q[j+1][k] <= q_q[j][k] | (take[j][k] ? STEPS'(1) << (OUT_FRAC - j) : '0);
        end
        l_q[j+1] <= l_q[j];
        n_q[j+1] <= n_q[j];
        z_q[j+1] <= z_q[j];
      end
    end
  end

  // Output register.
  logic [OUT_WIDTH-1:0] qx [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qx[k] = OUT_WIDTH'(q_q[STEPS][k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sv_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (z_q[STEPS]) begin
          nrm_q[k] <= '0;
        end else if (n_q[STEPS][k]) begin
          nrm_q[k] <= $signed(-qx[k]);
        end else begin
          nrm_q[k] <= $signed(qx[k]);
        end
      end
      out_zero_q <= z_q[STEPS];
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.normal_x = nrm_q[0];
  assign out_o.normal_y = nrm_q[1];
  assign out_o.normal_z = nrm_q[2];

  `TFN_ASSERT_IMP(degenerate_zero_a, clk_i, rst_ni, out_vld_q && out_zero_q, nrm_q[0] == '0 && nrm_q[1] == '0 && nrm_q[2] == '0)
  `TFN_ASSERT_IMP(unit_range_a, clk_i, rst_ni, out_vld_q, nrm_q[0] <= ONE_Q && nrm_q[0] >= -ONE_Q && nrm_q[1] <= ONE_Q && nrm_q[1] >= -ONE_Q && nrm_q[2] <= ONE_Q && nrm_q[2] >= -ONE_Q)
  `TFN_ASSERT_NXT(stall_holds_a, clk_i, rst_ni, !en, $stable(sv_q) && $stable(out_vld_q) && $stable(out_zero_q))
endmodule
`default_nettype wire
